// ----- design/pks_pkg.sv -----
// Shared types, codes and keyword tables for the presence keyword scanner.
`default_nettype none

package pks_pkg;

    localparam int WIN       = 12;
    localparam int WIN_IDX_W = 4;
    localparam int CNT_W     = 4;
    localparam int KW_MAX    = 12;
    localparam int KW_BITS   = 8 * KW_MAX;
    localparam int N_OLD     = 6;
    localparam int N_SUB     = 5;

    localparam logic [1:0] FMT_OLD = 2'd0;
    localparam logic [1:0] FMT_NEW = 2'd1;

    localparam logic [1:0] SUB_ACTIVE     = 2'd0;
    localparam logic [1:0] SUB_PENDING    = 2'd1;
    localparam logic [1:0] SUB_TERMINATED = 2'd2;

    localparam logic [3:0] ST_UNKNOWN = 4'd0;
    localparam logic [3:0] ST_PENDING = 4'd1;
    localparam logic [3:0] ST_ONLINE  = 4'd2;
    localparam logic [3:0] ST_BUSY    = 4'd3;
    localparam logic [3:0] ST_BRB     = 4'd4;
    localparam logic [3:0] ST_AWAY    = 4'd5;
    localparam logic [3:0] ST_PHONE   = 4'd6;
    localparam logic [3:0] ST_LUNCH   = 4'd7;
    localparam logic [3:0] ST_CLOSED  = 4'd8;

    typedef enum logic [1:0] {
        PH_TOP,
        PH_SUB,
        PH_DONE
    } t_phase;

    typedef logic [WIN-1:0][7:0] t_win;

    typedef struct packed {
        logic       first;
        logic       byte_valid;
        logic [7:0] body_byte;
        logic       last;
        logic [1:0] body_format;
        logic [1:0] sub_state;
    } t_item;

    typedef struct packed {
        logic [3:0] presence_status;
        logic       parse_error;
    } t_result;

    // Keyword text is left-justified: character i sits at bits [KW_BITS-1-8*i -: 8].
    typedef struct packed {
        logic [KW_BITS-1:0] text;
        logic [3:0]         len;
        logic [3:0]         code;
    } t_kw;

    function automatic t_kw old_kw(input logic [2:0] idx);
        t_kw k;
        case (idx)
            3'd0:    k = '{text: {"online", 48'd0},      len: 4'd6,  code: ST_ONLINE};
            3'd1:    k = '{text: {"busy", 64'd0},        len: 4'd4,  code: ST_BUSY};
            3'd2:    k = '{text: {"berightback", 8'd0},  len: 4'd11, code: ST_BRB};
            3'd3:    k = '{text: {"away", 64'd0},        len: 4'd4,  code: ST_AWAY};
            3'd4:    k = '{text: {"onthephone", 16'd0},  len: 4'd10, code: ST_PHONE};
            default: k = '{text: {"outtolunch", 16'd0},  len: 4'd10, code: ST_LUNCH};
        endcase
        return k;
    endfunction

    function automatic t_kw sub_kw(input logic [2:0] idx);
        t_kw k;
        case (idx)
            3'd0:    k = '{text: {"away", 64'd0},        len: 4'd4,  code: ST_AWAY};
            3'd1:    k = '{text: {"meal", 64'd0},        len: 4'd4,  code: ST_LUNCH};
            3'd2:    k = '{text: {"in-transit", 16'd0},  len: 4'd10, code: ST_BRB};
            3'd3:    k = '{text: {"busy", 64'd0},        len: 4'd4,  code: ST_BUSY};
            default: k = '{text: "on-the-phone",         len: 4'd12, code: ST_PHONE};
        endcase
        return k;
    endfunction

    localparam t_kw KW_OPEN   = '{text: {"open", 64'd0},    len: 4'd4, code: ST_ONLINE};
    localparam t_kw KW_CLOSED = '{text: {"closed", 48'd0},  len: 4'd6, code: ST_CLOSED};
    localparam t_kw KW_END    = '{text: {"/status", 40'd0}, len: 4'd7, code: ST_UNKNOWN};

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    // Match keyword k at window position p; the keyword must fit inside the n filled bytes.
    function automatic logic kw_hit(input t_win w, input logic [CNT_W-1:0] n, input int p,
                                    input t_kw k, input logic fold);
        logic       ok;
        logic [7:0] a;
        logic [7:0] b;
        int         idx;
        ok = ((p + int'(k.len)) <= int'(n));
        for (int i = 0; i < KW_MAX; i++) begin
            idx = p + i;
            if (i < int'(k.len) && idx < WIN) begin
                a = w[idx[WIN_IDX_W-1:0]];
                b = k.text[KW_BITS-1-8*i -: 8];
                if (fold && i > 0) begin
                    a = to_lower(a);
                end
                if (a != b) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- design/pks_if.sv -----
// Request and result channel interfaces of the presence keyword scanner.
`default_nettype none

interface pks_in_if;
    logic       valid;
    logic       ready;
    logic       first;
    logic       byte_valid;
    logic [7:0] body_byte;
    logic       last;
    logic [1:0] body_format;
    logic [1:0] sub_state;

    modport source (output valid, first, byte_valid, body_byte, last, body_format, sub_state,
                    input ready);
    modport sink   (input valid, first, byte_valid, body_byte, last, body_format, sub_state,
                    output ready);
endinterface

interface pks_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] presence_status;
    logic       parse_error;

    modport source (output valid, presence_status, parse_error, input ready);
    modport sink   (input valid, presence_status, parse_error, output ready);
endinterface

`default_nettype wire

// ----- design/pks_in_stage.sv -----
// Input register: holds one request until the scan core takes it.
`default_nettype none

module pks_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pks_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output pks_pkg::t_item o_item
);
    import pks_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // accept when empty or when the held request leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- design/pks_scan.sv -----
// Scan core: look-ahead window, keyword compare and status resolution.
`default_nettype none

module pks_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pks_pkg::t_item   i_item,
    input  logic             i_out_free,
    output logic             o_take,
    output pks_pkg::t_result o_result
);
    import pks_pkg::*;

    t_win             r_win;
    logic [CNT_W-1:0] r_cnt;
    t_phase           r_phase;
    logic [3:0]       r_status;
    logic [1:0]       r_fmt;
    logic [1:0]       r_sub;

    t_win             n_win;
    logic [CNT_W-1:0] n_cnt;
    t_phase           n_phase;
    logic [3:0]       n_status;
    logic [1:0]       n_fmt;
    logic [1:0]       n_sub;

    t_win             w;
    logic [CNT_W-1:0] base_cnt;
    logic [CNT_W-1:0] fill;
    logic             active;
    logic [WIN-1:0]   en;
    logic [3:0]       old_code [WIN];
    logic [3:0]       sub_code [WIN];
    logic [WIN-1:0]   open_h;
    logic [WIN-1:0]   closed_h;
    logic [WIN-1:0]   end_h;
    t_phase           ph;
    logic [3:0]       st;
    logic             go_sub;

    // a result-free request never waits on the output register
    assign o_take = i_valid && (!i_item.last || i_out_free);

    // latch format and state on the first request, insert the byte
    always_comb begin
        n_fmt    = i_item.first ? i_item.body_format : r_fmt;
        n_sub    = i_item.first ? i_item.sub_state : r_sub;
        base_cnt = i_item.first ? '0 : r_cnt;
        w        = r_win;
        fill     = base_cnt;
        if (i_item.byte_valid) begin
            w[base_cnt] = i_item.body_byte;
            fill        = base_cnt + 1'b1;
        end
        active = (n_sub != SUB_PENDING) && (n_sub != SUB_TERMINATED) && (n_fmt <= FMT_NEW);
    end

    // keyword hits at every window position, independent of each other
    always_comb begin
        for (int p = 0; p < WIN; p++) begin
            old_code[p] = ST_UNKNOWN;
            for (int i = N_OLD - 1; i >= 0; i--) begin
                if (kw_hit(w, fill, p, old_kw(3'(i)), 1'b0)) begin
                    old_code[p] = old_kw(3'(i)).code;
                end
            end
            sub_code[p] = ST_UNKNOWN;
            for (int i = N_SUB - 1; i >= 0; i--) begin
                if (kw_hit(w, fill, p, sub_kw(3'(i)), 1'b1)) begin
                    sub_code[p] = sub_kw(3'(i)).code;
                end
            end
            open_h[p]   = kw_hit(w, fill, p, KW_OPEN, 1'b1);
            closed_h[p] = kw_hit(w, fill, p, KW_CLOSED, 1'b1);
            end_h[p]    = kw_hit(w, fill, p, KW_END, 1'b1);
            // a full window decides its oldest byte; the last request flushes all filled bytes
            if (i_item.last) begin
                en[p] = active && (CNT_W'(p) < fill);
            end else begin
                en[p] = active && (p == 0) && (fill == CNT_W'(WIN));
            end
        end
    end

    // resolve decisions in byte order
    always_comb begin
        ph     = i_item.first ? PH_TOP : r_phase;
        st     = i_item.first ? ST_UNKNOWN : r_status;
        go_sub = 1'b0;
        for (int p = 0; p < WIN; p++) begin
            if (en[p] && ph != PH_DONE) begin
                go_sub = 1'b0;
                if (n_fmt == FMT_OLD) begin
                    if (old_code[p] != ST_UNKNOWN) begin
                        st = old_code[p];
                        ph = PH_DONE;
                    end
                end else begin
                    if (ph == PH_TOP) begin
                        if (open_h[p]) begin
                            st     = ST_ONLINE;
                            ph     = PH_SUB;
                            go_sub = 1'b1;
                        end else if (closed_h[p]) begin
                            st = ST_CLOSED;
                            ph = PH_DONE;
                        end
                    end else begin
                        go_sub = 1'b1;
                    end
                    if (go_sub) begin
                        if (sub_code[p] != ST_UNKNOWN) begin
                            st = sub_code[p];
                        end
                        if (end_h[p] || st != ST_ONLINE) begin
                            ph = PH_DONE;
                        end
                    end
                end
            end
        end
    end

    // next window, count, phase and status
    always_comb begin
        n_win = w;
        n_cnt = fill;
        if (fill == CNT_W'(WIN)) begin
            for (int k = 0; k < WIN - 1; k++) begin
                n_win[k] = w[k + 1];
            end
            n_win[WIN-1] = '0;
            n_cnt        = CNT_W'(WIN - 1);
        end
        n_phase  = ph;
        n_status = st;
        if (i_item.last) begin
            n_cnt    = '0;
            n_phase  = PH_TOP;
            n_status = ST_UNKNOWN;
        end
    end

    always_comb begin
        o_result.parse_error     = 1'b0;
        o_result.presence_status = st;
        if (n_sub == SUB_TERMINATED) begin
            o_result.presence_status = ST_UNKNOWN;
        end else if (n_sub == SUB_PENDING) begin
            o_result.presence_status = ST_PENDING;
        end else if (n_fmt > FMT_NEW) begin
            o_result.presence_status = ST_UNKNOWN;
            o_result.parse_error     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_phase  <= PH_TOP;
            r_status <= ST_UNKNOWN;
            r_fmt    <= FMT_OLD;
            r_sub    <= SUB_ACTIVE;
        end else if (o_take) begin
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
            r_status <= n_status;
            r_fmt    <= n_fmt;
            r_sub    <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_win <= n_win;
        end
    end

    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WIN - 1))
        else $error("look-ahead fill count beyond window");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.last) |=> (r_cnt == '0 && r_phase == PH_TOP && r_status == ST_UNKNOWN))
        else $error("scan state not cleared after last request");

    a_done_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_item.last && !i_item.first && r_phase == PH_DONE) |=>
        (r_phase == PH_DONE && $stable(r_status)))
        else $error("finished scan changed within a message");

endmodule

`default_nettype wire

// ----- design/pks_out_reg.sv -----
// Result register: holds one result until the sink takes it.
`default_nettype none

module pks_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pks_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output pks_pkg::t_result o_result,
    output logic             o_free
);
    import pks_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over a pending result");

    a_load_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_result == $past(i_result)))
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- design/presence_keyword_scanner.sv -----
// Top level of the presence keyword scanner: input register, scan core, result register.
// A result is registered in the result register when the scan core takes the last request
//   from the input register. Throughput: one request per cycle; a last request waits only while the result register
//   still holds an untaken result, set by the single result register.
// Reset (synchronous, active low) clears valid flags, fill count, scan phase, status and
//   the format and state latches; window bytes are not reset and are never read unfilled.
`default_nettype none

module presence_keyword_scanner (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pks_in_if.sink    i_item,
    pks_out_if.source o_result
);
    import pks_pkg::*;

    t_item   in_req;
    t_item   held_req;
    logic    held_valid;
    logic    take;
    logic    out_free;
    t_result scan_res;
    t_result out_res;
    logic    out_valid;

    // bundle the request fields
    assign in_req = '{
        first:       i_item.first,
        byte_valid:  i_item.byte_valid,
        body_byte:   i_item.body_byte,
        last:        i_item.last,
        body_format: i_item.body_format,
        sub_state:   i_item.sub_state
    };

    // hold the request in front of the scan logic
    pks_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_item  (in_req),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_req)
    );

    // advance the window and decide the oldest position of a full window or, on the last request, all filled positions
    pks_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_item     (held_req),
        .i_out_free (out_free),
        .o_take     (take),
        .o_result   (scan_res)
    );

    // register the result only for a last request
    pks_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && held_req.last),
        .i_result (scan_res),
        .i_ready  (o_result.ready),
        .o_valid  (out_valid),
        .o_result (out_res),
        .o_free   (out_free)
    );

    assign o_result.valid           = out_valid;
    assign o_result.presence_status = out_res.presence_status;
    assign o_result.parse_error     = out_res.parse_error;

endmodule

`default_nettype wire

// ----- tb/sv/presence_keyword_scanner_tb.sv -----
// Self-checking testbench for the presence keyword scanner: body streams against a status predictor.
`default_nettype none

module presence_keyword_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pks_pkg::*;

    // Codes the package leaves unnamed.
    localparam logic [1:0] FMT_UNKNOWN  = 2'd2;
    localparam logic [1:0] FMT_RESERVED = 2'd3;
    localparam logic [1:0] SUB_RESERVED = 2'd3;

    localparam int BYTE_TARGET   = 700;
    localparam int MESSAGE_FLOOR = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;

    // Ways a message body may be framed on the request channel.
    typedef enum int {
        BODY_CLEAN,
        BODY_NO_FIRST,
        BODY_RESTART,
        BODY_BLANKS,
        BODY_EMPTY_TAIL
    } t_framing;

    // Scoreboard: mirrors the scan state and queues the status each last request must yield.
    class presence_status_board;
        logic [7:0] window[WIN];
        int         fill;
        t_phase     phase;
        logic [3:0] status;
        logic [1:0] fmt_latch;
        logic [1:0] state_latch;
        string      old_text[N_OLD];
        logic [3:0] old_code[N_OLD];
        string      sub_text[N_SUB];
        logic [3:0] sub_code[N_SUB];
        t_result    status_due[$];
        int         errors;

        function new();
            old_text = '{"online", "busy", "berightback", "away", "onthephone", "outtolunch"};
            old_code = '{ST_ONLINE, ST_BUSY, ST_BRB, ST_AWAY, ST_PHONE, ST_LUNCH};
            sub_text = '{"away", "meal", "in-transit", "busy", "on-the-phone"};
            sub_code = '{ST_AWAY, ST_LUNCH, ST_BRB, ST_BUSY, ST_PHONE};
            fmt_latch   = FMT_OLD;
            state_latch = SUB_ACTIVE;
            errors      = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i]) window[i] = 8'h00;
            fill   = 0;
            phase  = PH_TOP;
            status = ST_UNKNOWN;
        endfunction

        function logic [7:0] fold(logic [7:0] b);
            return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        endfunction

        // Leading character must match exactly; the rest may fold case.
        function bit word_at(int pos, int avail, string kw, bit fold_case);
            int         n;
            logic [7:0] a;
            n = kw.len();
            if (pos >= WIN || n > avail || pos + n > WIN) return 1'b0;
            if (window[pos] != kw[0]) return 1'b0;
            for (int i = 1; i < n; i++) begin
                a = window[pos + i];
                if (fold_case) a = fold(a);
                if (a != kw[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit scanning();
            return state_latch != SUB_PENDING && state_latch != SUB_TERMINATED &&
                   fmt_latch <= FMT_NEW;
        endfunction

        function void decide(int pos, int count);
            int avail;
            bit found;
            if (phase == PH_DONE || pos >= count) return;
            avail = count - pos;
            if (fmt_latch == FMT_OLD) begin
                for (int i = 0; i < N_OLD; i++) begin
                    if (phase != PH_DONE && word_at(pos, avail, old_text[i], 1'b0)) begin
                        status = old_code[i];
                        phase  = PH_DONE;
                    end
                end
                return;
            end
            if (phase == PH_TOP) begin
                if (word_at(pos, avail, "open", 1'b1)) begin
                    status = ST_ONLINE;
                    phase  = PH_SUB;
                end else begin
                    if (word_at(pos, avail, "closed", 1'b1)) begin
                        status = ST_CLOSED;
                        phase  = PH_DONE;
                    end
                    return;
                end
            end
            found = 1'b0;
            for (int i = 0; i < N_SUB; i++) begin
                if (!found && word_at(pos, avail, sub_text[i], 1'b1)) begin
                    status = sub_code[i];
                    found  = 1'b1;
                end
            end
            if (word_at(pos, avail, "/status", 1'b1) || status != ST_ONLINE) phase = PH_DONE;
        endfunction

        function void note_request(t_item it);
            t_result r;
            if (it.first) begin
                fmt_latch   = it.body_format;
                state_latch = it.sub_state;
                clear_scan();
            end
            if (it.byte_valid) begin
                window[fill] = it.body_byte;
                fill++;
                if (fill == WIN) begin
                    if (scanning()) decide(0, WIN);
                    for (int i = 0; i < WIN - 1; i++) window[i] = window[i + 1];
                    window[WIN - 1] = 8'h00;
                    fill = WIN - 1;
                end
            end
            if (!it.last) return;
            if (scanning()) begin
                for (int i = 0; i < fill; i++) decide(i, fill);
            end
            r.presence_status = ST_UNKNOWN;
            r.parse_error     = 1'b0;
            if (state_latch == SUB_TERMINATED) begin
                r.presence_status = ST_UNKNOWN;
            end else if (state_latch == SUB_PENDING) begin
                r.presence_status = ST_PENDING;
            end else if (fmt_latch >= FMT_UNKNOWN) begin
                r.parse_error = 1'b1;
            end else begin
                r.presence_status = status;
            end
            status_due.push_back(r);
            clear_scan();
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (status_due.size() == 0) begin
                $display("%0t: result with none due: expected nothing, actual status %0d error %0b",
                         $time, got.presence_status, got.parse_error);
                errors++;
                return;
            end
            want = status_due.pop_front();
            if (got.presence_status != want.presence_status) begin
                $display("%0t: presence_status mismatch: expected %0d, actual %0d",
                         $time, want.presence_status, got.presence_status);
                errors++;
            end
            if (got.parse_error != want.parse_error) begin
                $display("%0t: parse_error mismatch: expected %0b, actual %0b",
                         $time, want.parse_error, got.parse_error);
                errors++;
            end
        endfunction

        function int outstanding();
            return status_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pks_in_if  in_if ();
    pks_out_if out_if ();

    presence_keyword_scanner dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_if),
        .o_result (out_if)
    );

    presence_status_board status_board = new();

    bit         idling    = 1'b0;
    int         hold_left = 0;
    int         bytes_sent;
    int         messages_sent;
    logic [7:0] body_q[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    // Result side ready: a long hold-off when requested, otherwise random stall bursts while idling is set.
    initial begin
        int stall;
        stall = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_if.ready <= 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Check every result taken at a rising edge.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.presence_status = out_if.presence_status;
            got.parse_error     = out_if.parse_error;
            status_board.check_result(got);
        end
    end

    // Fill every field with noise; callers override what matters.
    function automatic t_item random_item();
        t_item it;
        it.first       = 1'($urandom_range(0, 1));
        it.byte_valid  = 1'($urandom_range(0, 1));
        it.body_byte   = 8'($urandom_range(0, 255));
        it.last        = 1'($urandom_range(0, 1));
        it.body_format = 2'($urandom_range(0, 3));
        it.sub_state   = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // Enter and leave on a falling edge; hold the request until the edge that takes it.
    task automatic send_request(input t_item it);
        if (idling && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.first       <= it.first;
        in_if.byte_valid  <= it.byte_valid;
        in_if.body_byte   <= it.body_byte;
        in_if.last        <= it.last;
        in_if.body_format <= it.body_format;
        in_if.sub_state   <= it.sub_state;
        do @(posedge i_clk); while (!in_if.ready);
        status_board.note_request(it);
        if (it.byte_valid) bytes_sent++;
        @(negedge i_clk);
    endtask

    // Push the body in body_q as one message, framed as asked.
    task automatic send_message(input logic [1:0] fmt, input logic [1:0] sst,
                                input t_framing framing);
        t_item it;
        int    n;
        int    cut;
        n   = body_q.size();
        cut = (n > 2) ? $urandom_range(1, n - 1) : -1;
        messages_sent++;
        if (n == 0) begin
            it             = random_item();
            it.first       = (framing != BODY_NO_FIRST);
            it.byte_valid  = 1'b0;
            it.last        = 1'b1;
            it.body_format = fmt;
            it.sub_state   = sst;
            send_request(it);
            return;
        end
        for (int i = 0; i < n; i++) begin
            // Drop in requests that carry no byte.
            if (framing == BODY_BLANKS && i > 0 && $urandom_range(0, 3) == 0) begin
                it            = random_item();
                it.first      = 1'b0;
                it.byte_valid = 1'b0;
                it.last       = 1'b0;
                send_request(it);
            end
            it            = random_item();
            it.first      = (i == 0 && framing != BODY_NO_FIRST) ||
                            (framing == BODY_RESTART && i == cut);
            it.byte_valid = 1'b1;
            it.body_byte  = body_q[i];
            it.last       = (i == n - 1) && framing != BODY_EMPTY_TAIL;
            if (i == 0) begin
                it.body_format = fmt;
                it.sub_state   = sst;
            end
            send_request(it);
        end
        if (framing == BODY_EMPTY_TAIL) begin
            it            = random_item();
            it.first      = 1'b0;
            it.byte_valid = 1'b0;
            it.last       = 1'b1;
            send_request(it);
        end
    endtask

    // Append text, flipping letters to upper case at random when mangled.
    function automatic void add_text(string s, bit mangle);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mangle && c >= 8'h61 && c <= 8'h7A) begin
                if ((i > 0 && $urandom_range(0, 2) == 0) || (i == 0 && $urandom_range(0, 11) == 0))
                    c = c - 8'd32;
            end
            body_q.push_back(c);
        end
    endfunction

    // Mostly letters and markup, now and then any byte at all.
    function automatic void add_filler(int n);
        logic [7:0] c;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0:       c = 8'h3C;
                1:       c = 8'h3E;
                2:       c = 8'h2F;
                3:       c = 8'($urandom_range(0, 255));
                default: c = 8'($urandom_range(8'h61, 8'h7A));
            endcase
            body_q.push_back(c);
        end
    endfunction

    function automatic string pick_word();
        case ($urandom_range(0, 14))
            0:       return "online";
            1:       return "busy";
            2:       return "berightback";
            3:       return "away";
            4:       return "onthephone";
            5:       return "outtolunch";
            6:       return "open";
            7:       return "meal";
            8:       return "in-transit";
            9:       return "on-the-phone";
            10:      return "/status";
            11:      return "closed";
            12:      return "onlin";
            13:      return "/statu";
            default: return "ope";
        endcase
    endfunction

    // New-format bodies mostly lead with open or closed so the sub-keyword scan gets exercised.
    function automatic void build_body(bit new_fmt);
        body_q.delete();
        add_filler($urandom_range(0, 4));
        if (new_fmt && $urandom_range(0, 3) != 0) begin
            add_text(($urandom_range(0, 4) == 0) ? "closed" : "open", 1'b1);
            add_filler($urandom_range(0, 3));
        end
        repeat ($urandom_range(0, 2)) begin
            add_text(pick_word(), new_fmt || $urandom_range(0, 7) == 0);
            add_filler($urandom_range(0, 3));
        end
        // Cut the tail now and then so a keyword runs off the end.
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                if (body_q.size() > 0) void'(body_q.pop_back());
            end
        end
    endfunction

    function automatic void set_body(string s);
        body_q.delete();
        add_text(s, 1'b0);
    endfunction

    // Stop sending until every due status has been taken.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (status_board.outstanding() != 0);
    endtask

    initial begin
        bit          hold_done;
        bit          pause_done;
        int          pick;
        logic [1:0]  sst;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        bytes_sent    = 0;
        messages_sent = 0;

        in_if.valid       = 1'b0;
        in_if.first       = 1'b0;
        in_if.byte_valid  = 1'b0;
        in_if.body_byte   = 8'h00;
        in_if.last        = 1'b0;
        in_if.body_format = FMT_OLD;
        in_if.sub_state   = SUB_ACTIVE;
        i_rst_n           = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty body, the non-scanning states, bad formats, a hit in each format,
        // a keyword cut short by the end, and byte extremes closed by a byte-less last request.
        body_q.delete();
        send_message(FMT_OLD, SUB_ACTIVE, BODY_CLEAN);
        set_body("x");
        send_message(FMT_NEW, SUB_TERMINATED, BODY_CLEAN);
        set_body("a");
        send_message(FMT_OLD, SUB_PENDING, BODY_CLEAN);
        set_body("o");
        send_message(FMT_UNKNOWN, SUB_ACTIVE, BODY_CLEAN);
        set_body("z");
        send_message(FMT_RESERVED, SUB_RESERVED, BODY_CLEAN);
        set_body("busy");
        send_message(FMT_OLD, SUB_RESERVED, BODY_CLEAN);
        set_body("oPEN");
        send_message(FMT_NEW, SUB_ACTIVE, BODY_CLEAN);
        set_body("close");
        send_message(FMT_NEW, SUB_ACTIVE, BODY_CLEAN);
        body_q.delete();
        body_q.push_back(8'h00);
        body_q.push_back(8'hFF);
        body_q.push_back(8'h58);
        send_message(FMT_OLD, SUB_ACTIVE, BODY_EMPTY_TAIL);

        // Random: mostly well-formed bodies, some odd states and broken framing.
        idling = 1'b1;
        while (bytes_sent < BYTE_TARGET || messages_sent < MESSAGE_FLOOR) begin
            // Hold the result side off while short messages keep coming, so the block backs up.
            if (!hold_done && bytes_sent > 200) begin
                hold_done = 1'b1;
                idling    = 1'b0;
                hold_left = HOLD_CYCLES;
                repeat (12) begin
                    set_body(pick_word());
                    send_message(FMT_OLD, SUB_ACTIVE, BODY_CLEAN);
                end
                idling = 1'b1;
            end
            if (!pause_done && bytes_sent > 400) begin
                pause_done = 1'b1;
                wait_drained();
            end
            // Run the tail of the stimulus at full rate on both sides.
            if (bytes_sent > BYTE_TARGET * 85 / 100) idling = 1'b0;

            pick = $urandom_range(0, 99);
            sst  = ($urandom_range(0, 7) == 0) ? SUB_RESERVED : SUB_ACTIVE;
            if (pick < 45) begin
                build_body(1'b1);
                send_message(FMT_NEW, sst,
                             ($urandom_range(0, 7) == 0) ? BODY_BLANKS : BODY_CLEAN);
            end else if (pick < 75) begin
                build_body(1'b0);
                send_message(FMT_OLD, sst,
                             ($urandom_range(0, 7) == 0) ? BODY_BLANKS : BODY_CLEAN);
            end else if (pick < 88) begin
                build_body(1'($urandom_range(0, 1)));
                send_message(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), BODY_CLEAN);
            end else begin
                build_body(1'($urandom_range(0, 1)));
                send_message(2'($urandom_range(0, 1)), SUB_ACTIVE,
                             t_framing'($urandom_range(1, 4)));
            end
        end

        // Drain, then keep watching the result side for any stray result.
        in_if.valid <= 1'b0;
        while (status_board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (status_board.errors == 0 && status_board.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/pks_pkg.sv
design/pks_if.sv
design/pks_in_stage.sv
design/pks_scan.sv
design/pks_out_reg.sv
design/presence_keyword_scanner.sv
tb/sv/presence_keyword_scanner_tb.sv
